// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the modular exponentiation RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/mexp_pkg.sv =====
// Shared types and constants of the modular exponentiation unit.
package mexp_pkg;

  localparam int MOD_WIDTH   = 32;
  localparam int EXP_WIDTH   = 64;
  localparam int BASE_WIDTH  = 64;
  localparam int POWER_WIDTH = 32;
  localparam int CFG_WIDTH   = 32;
  localparam int IN_WIDTH    = BASE_WIDTH + 64;
  localparam int OUT_WIDTH   = POWER_WIDTH;
  localparam int CNT_WIDTH   = $clog2(BASE_WIDTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CHECK,
    ST_MUL_ACC,
    ST_SHIFT,
    ST_MUL_SQ,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    MUL_REDUCE,
    MUL_ACC,
    MUL_SQUARE
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_start;
    mul_sel_t sel;
    logic     acc_we;
    logic     sq_we;
    logic     exp_shift;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic mul_done;
    logic exp_zero;
    logic exp_last;
    logic exp_lsb;
  } dp_status_t;

endpackage

// ===== hw/rtl/mexp_mulmod.sv =====
// Bit-serial modular multiplier: one operand bit per cycle, MSB first.
module mexp_mulmod (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [mexp_pkg::MOD_WIDTH-1:0]    a,
  input  logic [mexp_pkg::BASE_WIDTH-1:0]   b,
  input  logic [mexp_pkg::CNT_WIDTH-1:0]    nbits,
  input  logic [mexp_pkg::MOD_WIDTH-1:0]    modulus,
  output logic [mexp_pkg::MOD_WIDTH-1:0]    result,
  output logic                              busy,
  output logic                              done
);

  localparam int SW = mexp_pkg::MOD_WIDTH + 2;

  logic [mexp_pkg::MOD_WIDTH-1:0]  r_r, r_nxt;
  logic [mexp_pkg::MOD_WIDTH-1:0]  a_r;
  logic [mexp_pkg::BASE_WIDTH-1:0] b_r;
  logic [mexp_pkg::CNT_WIDTH-1:0]  cnt_r;
  logic                            busy_r, done_r;
  logic [SW-1:0]                   s;
  logic [SW:0]                     d1, d2;

  always_comb begin
    s  = {1'b0, r_r, 1'b0} + (b_r[mexp_pkg::BASE_WIDTH-1] ? {2'b00, a_r} : '0);
    d1 = {1'b0, s} - (SW + 1)'(modulus);
    d2 = {1'b0, s} - (SW + 1)'({modulus, 1'b0});
    if (modulus == '0) begin
      r_nxt = s[mexp_pkg::MOD_WIDTH-1:0];
    end else if (!d2[SW]) begin
      r_nxt = d2[mexp_pkg::MOD_WIDTH-1:0];
    end else if (!d1[SW]) begin
      r_nxt = d1[mexp_pkg::MOD_WIDTH-1:0];
    end else begin
      r_nxt = s[mexp_pkg::MOD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == mexp_pkg::CNT_WIDTH'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r_r <= '0;
      a_r <= a;
      b_r <= b;
    end else if (busy_r) begin
      r_r <= r_nxt;
      b_r <= b_r << 1;
    end
  end

  assign result = r_r;
  assign busy   = busy_r;
  assign done   = done_r;

endmodule

// ===== hw/rtl/mexp_dp.sv =====
// Datapath: modulus register, running product, square, exponent and result.
module mexp_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [mexp_pkg::CFG_WIDTH-1:0]     cfg_wr_data,
  input  logic [mexp_pkg::BASE_WIDTH-1:0]    base,
  input  logic [63:0]                        exponent,
  input  mexp_pkg::dp_cmd_t                  cmd,
  output mexp_pkg::dp_status_t               status,
  output logic [mexp_pkg::POWER_WIDTH-1:0]   power
);

  logic [mexp_pkg::MOD_WIDTH-1:0]   modulus_r;
  logic [mexp_pkg::MOD_WIDTH-1:0]   acc_r;
  logic [mexp_pkg::MOD_WIDTH-1:0]   sq_r;
  logic [mexp_pkg::EXP_WIDTH-1:0]   exp_r;
  logic [mexp_pkg::POWER_WIDTH-1:0] power_r;
  logic [mexp_pkg::MOD_WIDTH-1:0]   mul_a;
  logic [mexp_pkg::BASE_WIDTH-1:0]  mul_b;
  logic [mexp_pkg::CNT_WIDTH-1:0]   mul_n;
  logic [mexp_pkg::MOD_WIDTH-1:0]   mul_result;
  logic                             mul_busy, mul_done;

  always_comb begin
    case (cmd.sel)
      mexp_pkg::MUL_REDUCE: begin
        mul_a = mexp_pkg::MOD_WIDTH'(1);
        mul_b = base;
        mul_n = mexp_pkg::CNT_WIDTH'(mexp_pkg::BASE_WIDTH);
      end
      mexp_pkg::MUL_ACC: begin
        mul_a = acc_r;
        mul_b = mexp_pkg::BASE_WIDTH'(sq_r) << (mexp_pkg::BASE_WIDTH - mexp_pkg::MOD_WIDTH);
        mul_n = mexp_pkg::CNT_WIDTH'(mexp_pkg::MOD_WIDTH);
      end
      mexp_pkg::MUL_SQUARE: begin
        mul_a = sq_r;
        mul_b = mexp_pkg::BASE_WIDTH'(sq_r) << (mexp_pkg::BASE_WIDTH - mexp_pkg::MOD_WIDTH);
        mul_n = mexp_pkg::CNT_WIDTH'(mexp_pkg::MOD_WIDTH);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
        mul_n = '0;
      end
    endcase
  end

  mexp_mulmod u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .nbits   (mul_n),
    .modulus (modulus_r),
    .result  (mul_result),
    .busy    (mul_busy),
    .done    (mul_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= mexp_pkg::MOD_WIDTH'(1);
    end else if (cfg_wr_en) begin
      modulus_r <= cfg_wr_data[mexp_pkg::MOD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_r <= mexp_pkg::MOD_WIDTH'(1);
      exp_r <= exponent[mexp_pkg::EXP_WIDTH-1:0];
    end else begin
      if (cmd.acc_we) begin
        acc_r <= mul_result;
      end
      if (cmd.exp_shift) begin
        exp_r <= exp_r >> 1;
      end
    end
    if (cmd.sq_we) begin
      sq_r <= mul_result;
    end
    if (cmd.out_load) begin
      power_r <= mexp_pkg::POWER_WIDTH'(acc_r);
    end
  end

  always_comb begin
    status.mul_busy = mul_busy;
    status.mul_done = mul_done;
    status.exp_zero = (exp_r == '0);
    status.exp_last = ((exp_r >> 1) == '0);
    status.exp_lsb  = exp_r[0];
  end

  assign power = power_r;

endmodule

// ===== hw/rtl/mexp_ctrl.sv =====
// Controller: sequences reduction, multiply and square steps per request.
module mexp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  mexp_pkg::dp_status_t  status,
  output mexp_pkg::dp_cmd_t     cmd
);

  mexp_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mexp_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = mexp_pkg::ST_REDUCE;
        end
      end
      mexp_pkg::ST_REDUCE: begin
        if (status.mul_done) begin
          state_nxt = mexp_pkg::ST_CHECK;
        end
      end
      mexp_pkg::ST_CHECK: begin
        if (status.exp_zero) begin
          state_nxt = mexp_pkg::ST_FINISH;
        end else if (status.exp_lsb) begin
          state_nxt = mexp_pkg::ST_MUL_ACC;
        end else begin
          state_nxt = mexp_pkg::ST_SHIFT;
        end
      end
      mexp_pkg::ST_MUL_ACC: begin
        if (status.mul_done) begin
          state_nxt = mexp_pkg::ST_SHIFT;
        end
      end
      mexp_pkg::ST_SHIFT: begin
        if (status.exp_last) begin
          state_nxt = mexp_pkg::ST_FINISH;
        end else begin
          state_nxt = mexp_pkg::ST_MUL_SQ;
        end
      end
      mexp_pkg::ST_MUL_SQ: begin
        if (status.mul_done) begin
          state_nxt = mexp_pkg::ST_CHECK;
        end
      end
      mexp_pkg::ST_FINISH: begin
        if (slot_free) begin
          state_nxt = mexp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mexp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.sel       = mexp_pkg::MUL_REDUCE;
    in_tready     = 1'b0;
    case (state_r)
      mexp_pkg::ST_IDLE: begin
        in_tready     = 1'b1;
        cmd.load      = in_tvalid;
        cmd.mul_start = in_tvalid;
      end
      mexp_pkg::ST_REDUCE: begin
        cmd.sq_we = status.mul_done;
      end
      mexp_pkg::ST_CHECK: begin
        cmd.sel       = mexp_pkg::MUL_ACC;
        cmd.mul_start = !status.exp_zero && status.exp_lsb;
      end
      mexp_pkg::ST_MUL_ACC: begin
        cmd.acc_we = status.mul_done;
      end
      mexp_pkg::ST_SHIFT: begin
        cmd.sel       = mexp_pkg::MUL_SQUARE;
        cmd.exp_shift = 1'b1;
        cmd.mul_start = !status.exp_last;
      end
      mexp_pkg::ST_MUL_SQ: begin
        cmd.sq_we = status.mul_done;
      end
      mexp_pkg::ST_FINISH: begin
        cmd.out_load = slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mexp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== hw/rtl/modular_exponentiation_unit.sv =====
// Sequence: base reduction, then per exponent bit up to the highest set bit a check,
// a multiply into the product when the bit is set, a shift and (but for the last bit) a square.
// Throughput: one request at a time; the bit-serial modular multiplier (one bit
// per cycle, 32 bits per product, 64 for the base reduction) sets the rate.
// Reset (synchronous, rst_n low): idle, no result pending, modulus back to 1.
module modular_exponentiation_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [mexp_pkg::CFG_WIDTH-1:0]    cfg_wr_data,  // modulus
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mexp_pkg::IN_WIDTH-1:0]     in_tdata,     // base[63:0], exponent[127:64]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mexp_pkg::OUT_WIDTH-1:0]    out_tdata     // power[31:0]
);

`include "assert_macros.svh"

  mexp_pkg::dp_cmd_t    cmd;
  mexp_pkg::dp_status_t status;
  logic [mexp_pkg::POWER_WIDTH-1:0] power;

  mexp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  mexp_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .base        (in_tdata[mexp_pkg::BASE_WIDTH-1:0]),
    .exponent    (in_tdata[mexp_pkg::IN_WIDTH-1:mexp_pkg::BASE_WIDTH]),
    .cmd         (cmd),
    .status      (status),
    .power       (power)
  );

  assign out_tdata = mexp_pkg::OUT_WIDTH'(power);

  `ASSERT_NEXT(a_busy_after_request, clk, rst_n, in_tvalid && in_tready, !in_tready, "ready after accepted request")
  `ASSERT_IMPLIES(a_no_start_while_busy, clk, rst_n, cmd.mul_start, !status.mul_busy, "multiplier restarted while busy")
  `ASSERT_NEXT(a_result_after_load, clk, rst_n, cmd.out_load, out_tvalid, "result not presented after load")
  `ASSERT_IMPLIES(a_load_only_when_free, clk, rst_n, cmd.out_load, !out_tvalid || out_tready, "pending result overwritten")

endmodule
